/* src/lgpf_pkg.sv */
package lgpf_pkg;

  localparam int PIXEL_W = 8;
  localparam int SLICE_W = 4;
  localparam int LABEL_W = 4;
  localparam int COUNT_W = 11;
  localparam int SLICE_EXT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic FUNC_PAINT = 1'b0;
  localparam logic FUNC_FILL  = 1'b1;

  typedef enum logic [1:0] {
    NB_ROW_INC,
    NB_ROW_DEC,
    NB_COL_INC,
    NB_COL_DEC
  } nb_t;

  function automatic nb_t nb_next(input nb_t k);
    nb_t n;
    case (k)
      NB_ROW_INC: n = NB_ROW_DEC;
      NB_ROW_DEC: n = NB_COL_INC;
      NB_COL_INC: n = NB_COL_DEC;
      default:    n = NB_ROW_INC;
    endcase
    return n;
  endfunction

endpackage

/* src/lgpf_grid.sv */
module lgpf_grid #(
  parameter int GRID_DEPTH      = 16384,
  parameter int ADDR_W          = 14,
  parameter int UNDEFINED_LABEL = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [ADDR_W-1:0]               rd_addr,
  output logic [lgpf_pkg::LABEL_W-1:0]    rd_data,
  input  logic                            wr_en,
  input  logic [ADDR_W-1:0]               wr_addr,
  input  logic [lgpf_pkg::LABEL_W-1:0]    wr_data,
  output logic                            clearing
);

  import lgpf_pkg::*;

  logic [LABEL_W-1:0] mem [GRID_DEPTH];
  logic [LABEL_W-1:0] rd_q;
  logic [LABEL_W-1:0] fwd_data;
  logic               fwd_hit;
  logic [ADDR_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(GRID_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= LABEL_W'(UNDEFINED_LABEL);
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    fwd_hit  <= rd_en && wr_en && (rd_addr == wr_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

/* src/lgpf_fifo.sv */
module lgpf_fifo #(
  parameter int CELL_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              push,
  input  logic [CELL_W-1:0] push_data,
  input  logic              pop,
  output logic [CELL_W-1:0] pop_data,
  output logic              empty
);

  import lgpf_pkg::*;

  localparam int DEPTH = 1 << CELL_W;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] head;
  logic [CELL_W-1:0] tail;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[head];
    end
  end

  assign empty = (head == tail);

endmodule

/* src/label_grid_paint_and_fill.sv */
// Paint and four-connected fill over a grid of 4-bit colour labels, SLICES slices of
// (256 >> ROW_SHIFT) x (256 >> COL_SHIFT) cells. A request is taken when start is high
// and busy is low; its single result appears for exactly one cycle with done high and
// must be captured then, since the block cannot be stalled. A paint or a rejected label
// gives its result in the cycle after the transfer and busy stays low. A fill whose seed
// already holds the label finishes after the seed read with no cell changed; otherwise
// each recoloured cell costs four neighbour reads on the grid memory's single read port,
// and each time the cell queue runs dry before the walk has ended the walk passes through
// a drain and a pop state. After reset the grid memory is swept to the undefined label,
// one entry a cycle, SLICES * cells-per-slice entries (16384 by default), with busy high.
module label_grid_paint_and_fill #(
  parameter int SLICES          = 16,
  parameter int ROW_SHIFT       = 3,
  parameter int COL_SHIFT       = 3,
  parameter int COLOUR_COUNT    = 8,
  parameter int UNDEFINED_LABEL = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [lgpf_pkg::SLICE_W-1:0]  slice,
  input  logic [lgpf_pkg::PIXEL_W-1:0]  pixel_u,
  input  logic [lgpf_pkg::PIXEL_W-1:0]  pixel_v,
  input  logic [lgpf_pkg::LABEL_W-1:0]  paint_label,
  output logic                          done,
  output logic [lgpf_pkg::COUNT_W-1:0]  cells_changed,
  output logic                          rejected
);

  import lgpf_pkg::*;

  localparam int ROW_W       = PIXEL_W - ROW_SHIFT;
  localparam int COL_W       = PIXEL_W - COL_SHIFT;
  localparam int CELL_W      = ROW_W + COL_W;
  localparam int SLICE_CELLS = 1 << CELL_W;
  localparam int GRID_DEPTH  = SLICES * SLICE_CELLS;
  localparam int GA_W        = $clog2(GRID_DEPTH);
  localparam int SL_W        = (SLICES > 1) ? $clog2(SLICES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_WALK,
    S_DRAIN,
    S_POP
  } state_t;

  state_t             state;
  nb_t                k;
  logic [LABEL_W-1:0] lab;
  logic [SL_W-1:0]    sl;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic               load_cur;
  logic               chk_valid;
  logic               chk_ok;
  logic [CELL_W-1:0]  chk_cell;
  logic [COUNT_W-1:0] count;

  logic                   clearing;
  logic                   accept;
  logic                   lab_bad;
  logic [ROW_W-1:0]       req_row;
  logic [COL_W-1:0]       req_col;
  logic [SLICE_EXT_W-1:0] slice_ext;
  logic [SLICE_EXT_W-1:0] slice_sat;
  logic [SL_W-1:0]        req_sl;
  logic [ROW_W-1:0]       cur_row_now;
  logic [COL_W-1:0]       cur_col_now;
  logic [ROW_W-1:0]       nb_row;
  logic [COL_W-1:0]       nb_col;
  logic                   nb_ok;
  logic                   chk_hit;
  logic                   seed_differs;

  logic                   grid_rd_en;
  logic [GA_W-1:0]        grid_rd_addr;
  logic [LABEL_W-1:0]     grid_rd_data;
  logic                   grid_wr_en;
  logic [GA_W-1:0]        grid_wr_addr;
  logic [LABEL_W-1:0]     grid_wr_data;

  logic                   fifo_clear;
  logic                   fifo_pop;
  logic [CELL_W-1:0]      fifo_q;
  logic                   fifo_empty;

  assign busy    = clearing || (state != S_IDLE);
  assign accept  = start && !busy;
  assign lab_bad = (paint_label >= LABEL_W'(COLOUR_COUNT));
  assign req_row = pixel_u[PIXEL_W-1 -: ROW_W];
  assign req_col = pixel_v[PIXEL_W-1 -: COL_W];

  assign slice_ext = {{(SLICE_EXT_W - SLICE_W){1'b0}}, slice};
  assign slice_sat = (slice_ext >= SLICE_EXT_W'(SLICES)) ? SLICE_EXT_W'(SLICES - 1) : slice_ext;
  assign req_sl    = slice_sat[SL_W-1:0];

  assign cur_row_now = load_cur ? fifo_q[CELL_W-1 -: ROW_W] : cur_row;
  assign cur_col_now = load_cur ? fifo_q[COL_W-1:0] : cur_col;

  always_comb begin
    nb_row = cur_row_now;
    nb_col = cur_col_now;
    nb_ok  = 1'b0;
    case (k)
      NB_ROW_INC: begin
        nb_row = cur_row_now + 1'b1;
        nb_ok  = (cur_row_now != '1);
      end
      NB_ROW_DEC: begin
        nb_row = cur_row_now - 1'b1;
        nb_ok  = (cur_row_now != '0);
      end
      NB_COL_INC: begin
        nb_col = cur_col_now + 1'b1;
        nb_ok  = (cur_col_now != '1);
      end
      default: begin
        nb_col = cur_col_now - 1'b1;
        nb_ok  = (cur_col_now != '0);
      end
    endcase
  end

  assign chk_hit      = chk_valid && chk_ok && (grid_rd_data != lab);
  assign seed_differs = (state == S_SEED) && (grid_rd_data != lab);

  assign grid_rd_en   = (accept && (func == FUNC_FILL) && !lab_bad) || (state == S_WALK);
  assign grid_rd_addr = (state == S_WALK) ? GA_W'({sl, nb_row, nb_col})
                                          : GA_W'({req_sl, req_row, req_col});

  assign grid_wr_en   = (accept && (func == FUNC_PAINT) && !lab_bad) || seed_differs || chk_hit;
  assign grid_wr_data = (state == S_IDLE) ? paint_label : lab;

  always_comb begin
    case (state)
      S_IDLE:  grid_wr_addr = GA_W'({req_sl, req_row, req_col});
      S_SEED:  grid_wr_addr = GA_W'({sl, cur_row, cur_col});
      default: grid_wr_addr = GA_W'({sl, chk_cell});
    endcase
  end

  assign fifo_clear = (state == S_SEED);
  assign fifo_pop   = !fifo_empty &&
                      (((state == S_WALK) && (k == NB_COL_DEC)) || (state == S_POP));

  lgpf_grid #(
    .GRID_DEPTH      (GRID_DEPTH),
    .ADDR_W          (GA_W),
    .UNDEFINED_LABEL (UNDEFINED_LABEL)
  ) u_grid (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (grid_rd_en),
    .rd_addr  (grid_rd_addr),
    .rd_data  (grid_rd_data),
    .wr_en    (grid_wr_en),
    .wr_addr  (grid_wr_addr),
    .wr_data  (grid_wr_data),
    .clearing (clearing)
  );

  lgpf_fifo #(
    .CELL_W (CELL_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .clear     (fifo_clear),
    .push      (chk_hit),
    .push_data (chk_cell),
    .pop       (fifo_pop),
    .pop_data  (fifo_q),
    .empty     (fifo_empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= NB_ROW_INC;
      done      <= 1'b0;
      load_cur  <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done      <= 1'b0;
      load_cur  <= 1'b0;
      chk_valid <= 1'b0;
      if (chk_hit && (count != COUNT_MAX)) begin
        count <= count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            lab     <= paint_label;
            sl      <= req_sl;
            cur_row <= req_row;
            cur_col <= req_col;
            if (lab_bad) begin
              done          <= 1'b1;
              cells_changed <= '0;
              rejected      <= 1'b1;
            end else if (func == FUNC_PAINT) begin
              done          <= 1'b1;
              cells_changed <= COUNT_W'(1);
              rejected      <= 1'b0;
            end else begin
              state <= S_SEED;
            end
          end
        end
        S_SEED: begin
          if (!seed_differs) begin
            done          <= 1'b1;
            cells_changed <= '0;
            rejected      <= 1'b0;
            state         <= S_IDLE;
          end else begin
            count <= COUNT_W'(1);
            k     <= NB_ROW_INC;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          cur_row   <= cur_row_now;
          cur_col   <= cur_col_now;
          chk_valid <= 1'b1;
          chk_ok    <= nb_ok;
          chk_cell  <= {nb_row, nb_col};
          k         <= nb_next(k);
          if (k == NB_COL_DEC) begin
            if (!fifo_empty) begin
              load_cur <= 1'b1;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          state <= S_POP;
        end
        S_POP: begin
          if (!fifo_empty) begin
            load_cur <= 1'b1;
            k        <= NB_ROW_INC;
            state    <= S_WALK;
          end else begin
            done          <= 1'b1;
            cells_changed <= count;
            rejected      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((func == FUNC_PAINT) || lab_bad)) |=> (done && !busy))
    else $error("paint or rejected request did not finish in one cycle");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> (cells_changed == '0))
    else $error("rejected request reports changed cells");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> (!fifo_empty && ((state == S_WALK) || (state == S_POP))))
    else $error("cell queue read while empty");

  a_no_write_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!grid_wr_en && !grid_rd_en))
    else $error("grid access during clearing sweep");
`endif

endmodule
